### src/rrbi_pkg.sv
package rrbi_pkg;

	localparam int NUM_QUEUES  = 8;
	localparam int QUEUE_DEPTH = 16;

	localparam int QW     = $clog2(NUM_QUEUES);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(RAM_DEPTH);
	localparam int BURST_W = 5;
	localparam int FQ_DEPTH = 2;

	localparam logic       CMD_PUSH   = 1'b0;
	localparam logic       CMD_PULL   = 1'b1;
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [2:0] queue_index;
		logic [7:0] push_value;
	} request_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_value;
		logic [2:0] out_queue;
	} result_t;

	typedef enum logic {
		OP_PUSH,
		OP_PULL
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic       bad_index;
		logic [2:0] queue_index;
		logic [7:0] push_value;
	} op_t;

	function automatic logic [QW-1:0] next_queue(input logic [QW-1:0] q);
		logic [QW-1:0] r;
		if (q == QW'(NUM_QUEUES - 1)) begin
			r = '0;
		end else begin
			r = q + QW'(1);
		end
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] ram_addr(input logic [QW-1:0] q,
		input logic [PTR_W-1:0] p);
		return ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(p);
	endfunction

endpackage

### src/rrbi_ram.sv
module rrbi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/rrbi_front.sv
module rrbi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rrbi_pkg::request_t req,
	input  logic              take,
	output logic              op_valid,
	output rrbi_pkg::op_t     op
);
	import rrbi_pkg::*;

	localparam int FP_W = $clog2(FQ_DEPTH);

	op_t              fq_mem_q [FQ_DEPTH];
	logic [FP_W-1:0]  wr_ptr_q;
	logic [FP_W-1:0]  rd_ptr_q;
	logic [FP_W:0]    cnt_q;
	logic             accept;
	logic             pop;
	op_t              new_op;

	assign busy     = (cnt_q == (FP_W+1)'(FQ_DEPTH));
	assign accept   = start && !busy;
	assign op_valid = (cnt_q != '0);
	assign pop      = take && op_valid;
	assign op       = fq_mem_q[rd_ptr_q];

	// classify the request before queueing it
	always_comb begin
		new_op.kind        = (req.cmd == CMD_PULL) ? OP_PULL : OP_PUSH;
		new_op.bad_index   = (32'(req.queue_index) >= NUM_QUEUES);
		new_op.queue_index = req.queue_index;
		new_op.push_value  = req.push_value;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fq_mem_q[wr_ptr_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == FP_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_q + FP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FP_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_q + FP_W'(1);
			end
			if (accept && !pop) begin
				cnt_q <= cnt_q + (FP_W+1)'(1);
			end else if (pop && !accept) begin
				cnt_q <= cnt_q - (FP_W+1)'(1);
			end
		end
	end

endmodule

### src/rrbi_back.sv
module rrbi_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rrbi_pkg::BURST_W-1:0]  cfg_wdata,
	input  logic                          op_valid,
	input  rrbi_pkg::op_t                 op,
	output logic                          take,
	output logic                          result_valid,
	output rrbi_pkg::result_t             result
);
	import rrbi_pkg::*;

	logic [CNT_W-1:0]   fill_q [NUM_QUEUES];
	logic [PTR_W-1:0]   head_q [NUM_QUEUES];
	logic [PTR_W-1:0]   tail_q [NUM_QUEUES];
	logic [QW-1:0]      cur_q;
	logic [BURST_W-1:0] taken_q;
	logic [BURST_W-1:0] burst_q;

	logic               res_valid_s1;
	logic [1:0]         res_status_s1;
	logic [2:0]         res_queue_s1;
	logic               res_pull_s1;

	logic [NUM_QUEUES-1:0] nonempty;
	logic [BURST_W-1:0]    limit;
	logic                  adv;
	logic [QW-1:0]         q0;
	logic [QW:0]           cand;
	logic [QW-1:0]         pick;
	logic [BURST_W-1:0]    taken_inc;
	logic                  end_burst;
	logic [QW-1:0]         push_idx;
	logic                  push_ok;
	logic                  pull_ok;
	logic                  do_push;
	logic                  do_pull;
	logic [7:0]            rdata;

	assign take = op_valid;

	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			nonempty[i] = (fill_q[i] != '0);
		end
	end

	assign limit = (burst_q == '0) ? BURST_W'(1) : burst_q;
	assign adv   = (taken_q >= limit);
	assign q0    = adv ? next_queue(cur_q) : cur_q;

	// round-robin pick: first non-empty queue at or after q0
	always_comb begin
		pick = q0;
		cand = '0;
		for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
			cand = {1'b0, q0} + (QW+1)'(i);
			if (cand >= (QW+1)'(NUM_QUEUES)) begin
				cand = cand - (QW+1)'(NUM_QUEUES);
			end
			if (nonempty[cand[QW-1:0]]) begin
				pick = cand[QW-1:0];
			end
		end
	end

	assign taken_inc = (adv || !nonempty[q0]) ? BURST_W'(1) : taken_q + BURST_W'(1);
	assign end_burst = (taken_inc >= limit) || (fill_q[pick] == CNT_W'(1));

	assign push_idx = QW'(op.queue_index);
	assign push_ok  = !op.bad_index && (fill_q[push_idx] != CNT_W'(QUEUE_DEPTH));
	assign pull_ok  = |nonempty;
	assign do_push  = op_valid && (op.kind == OP_PUSH) && push_ok;
	assign do_pull  = op_valid && (op.kind == OP_PULL) && pull_ok;

	rrbi_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (ram_addr(push_idx, tail_q[push_idx])),
		.wdata (op.push_value),
		.raddr (ram_addr(pick, head_q[pick])),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				fill_q[i] <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			cur_q   <= '0;
			taken_q <= '0;
			burst_q <= BURST_W'(1);
		end else begin
			if (cfg_we) begin
				burst_q <= cfg_wdata;
			end
			if (do_push) begin
				tail_q[push_idx] <= next_ptr(tail_q[push_idx]);
				fill_q[push_idx] <= fill_q[push_idx] + CNT_W'(1);
			end
			if (do_pull) begin
				head_q[pick] <= next_ptr(head_q[pick]);
				fill_q[pick] <= fill_q[pick] - CNT_W'(1);
				if (end_burst) begin
					cur_q   <= next_queue(pick);
					taken_q <= '0;
				end else begin
					cur_q   <= pick;
					taken_q <= taken_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else begin
			res_valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_pull_s1  <= do_pull;
		res_queue_s1 <= do_pull ? 3'(pick) : 3'd0;
		if (op.kind == OP_PUSH) begin
			res_status_s1 <= push_ok ? STAT_OK : STAT_FULL;
		end else begin
			res_status_s1 <= pull_ok ? STAT_OK : STAT_EMPTY;
		end
	end

	// ram data lands with the result stage
	assign result_valid     = res_valid_s1;
	assign result.status    = res_status_s1;
	assign result.out_value = res_pull_s1 ? rdata : 8'd0;
	assign result.out_queue = res_queue_s1;

endmodule

### src/round_robin_burst_interleaver_unit.sv
// round-robin burst interleaver over NUM_QUEUES fifo queues of 8-bit values
//
// request channel: drive req and raise start; the request is taken at a
// rising edge where start is high and busy is low. cmd push appends
// push_value to queue_index, cmd pull returns the next value in
// round-robin order, at most burst_size values per queue before moving on.
// result channel: every request gives one result, shown on result for one
// cycle with result_valid high; there is no back-pressure on it.
// throughput: one request per cycle, set by the back end doing one queue
// update and one queue-store access each cycle; the two-entry request
// queue keeps busy low in steady use.
// configuration: cfg_we with cfg_wdata writes burst_size (0 acts as 1); the user
// writes it only while no request is outstanding, the block does not enforce it.
// reset: arst_n clears all queues, the round-robin position and burst
// count, sets burst_size to 1 and drops any queued request; no clearing
// pass is needed.
module round_robin_burst_interleaver_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  rrbi_pkg::request_t            req,
	input  logic                          cfg_we,
	input  logic [rrbi_pkg::BURST_W-1:0]  cfg_wdata,
	output logic                          result_valid,
	output rrbi_pkg::result_t             result
);
	import rrbi_pkg::*;

	logic take;
	logic op_valid;
	op_t  op;

	rrbi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.take     (take),
		.op_valid (op_valid),
		.op       (op)
	);

	rrbi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.op_valid     (op_valid),
		.op           (op),
		.take         (take),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

### src/rrbi_checker.sv
module rrbi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          result_valid,
	input rrbi_pkg::result_t             result
);
	import rrbi_pkg::*;

	// every taken request comes back as one result
	a_req_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 result_valid)
		else $error("request without result");

	a_result_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, 2))
		else $error("result without request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == STAT_OK || result.status == STAT_FULL ||
			result.status == STAT_EMPTY))
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != STAT_OK) |->
			(result.out_value == 8'd0 && result.out_queue == 3'd0))
		else $error("failed request carries data");

endmodule

bind round_robin_burst_interleaver_unit rrbi_checker u_rrbi_checker (.*);

### tb/round_robin_burst_interleaver_unit_tb.sv
module round_robin_burst_interleaver_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rrbi_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_LIMIT = 500;
	localparam int SEGMENTS    = 17;
	localparam int SEG_ITEMS   = 50;

	class interleave_tracker;
		logic [7:0]  store [RAM_DEPTH];
		int unsigned head_pos [NUM_QUEUES];
		int unsigned tail_pos [NUM_QUEUES];
		int unsigned fill [NUM_QUEUES];
		int unsigned serving;
		int unsigned taken;
		int unsigned burst_len;
		result_t     pending_results [$];
		int          errors;
		int          pushes;
		int          pulls;
		int          refused;
		int          dry_pulls;

		function new();
			foreach (store[i]) store[i] = '0;
			foreach (fill[i]) begin
				head_pos[i] = 0;
				tail_pos[i] = 0;
				fill[i] = 0;
			end
			serving = 0;
			taken = 0;
			burst_len = 1;
			errors = 0;
			pushes = 0;
			pulls = 0;
			refused = 0;
			dry_pulls = 0;
		endfunction

		function void set_burst(int unsigned v);
			burst_len = v & 32'h1f;
		endfunction

		function result_t predict_interleave(request_t r);
			result_t     res;
			int unsigned lim;
			int unsigned q;
			int unsigned qi;
			bit          any;
			res = '0;
			lim = (burst_len == 0) ? 1 : burst_len;
			qi = r.queue_index;
			if (r.cmd == CMD_PUSH) begin
				pushes++;
				if (qi >= NUM_QUEUES || fill[qi] >= QUEUE_DEPTH) begin
					res.status = STAT_FULL;
					refused++;
				end else begin
					store[qi * QUEUE_DEPTH + tail_pos[qi]] = r.push_value;
					tail_pos[qi] = (tail_pos[qi] + 1) % QUEUE_DEPTH;
					fill[qi]++;
				end
			end else begin
				pulls++;
				any = 0;
				foreach (fill[i]) if (fill[i] != 0) any = 1;
				if (!any) begin
					res.status = STAT_EMPTY;
					dry_pulls++;
				end else begin
					q = serving % NUM_QUEUES;
					// a lowered burst size may already be used up
					if (taken >= lim) begin
						q = (q + 1) % NUM_QUEUES;
						taken = 0;
					end
					for (int i = 0; i < NUM_QUEUES; i++) begin
						if (fill[q] != 0) break;
						q = (q + 1) % NUM_QUEUES;
						taken = 0;
					end
					res.status = STAT_OK;
					res.out_value = store[q * QUEUE_DEPTH + head_pos[q]];
					res.out_queue = q[2:0];
					head_pos[q] = (head_pos[q] + 1) % QUEUE_DEPTH;
					fill[q]--;
					taken++;
					if (taken >= lim || fill[q] == 0) begin
						q = (q + 1) % NUM_QUEUES;
						taken = 0;
					end
					serving = q;
				end
			end
			return res;
		endfunction

		function void note_request(request_t r);
			pending_results.insert(pending_results.size(), predict_interleave(r));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d out_value %0d out_queue %0d",
					got.status, got.out_value, got.out_queue);
				errors++;
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.out_value !== want.out_value) begin
				$error("out_value: expected %0d, actual %0d", want.out_value, got.out_value);
				errors++;
			end
			if (got.out_queue !== want.out_queue) begin
				$error("out_queue: expected %0d, actual %0d", want.out_queue, got.out_queue);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	request_t           req;
	logic               cfg_we;
	logic [BURST_W-1:0] cfg_wdata;
	logic               result_valid;
	result_t            result;

	interleave_tracker  tracker;
	int                 idle_pct;
	int                 stall_cycles;
	int                 cfg_writes;

	round_robin_burst_interleaver_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			tracker.check_result(result);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("round_robin_burst_interleaver_unit: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// start stays high across back-to-back requests
	task automatic send_request(input request_t r);
		req <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		tracker.note_request(r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_fields(input logic c, input int q, input int v);
		request_t r;
		r.cmd = c;
		r.queue_index = q[2:0];
		r.push_value = v[7:0];
		send_request(r);
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (tracker.outstanding() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_burst(input int unsigned v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v[BURST_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_burst(v);
		cfg_writes++;
	endtask

	initial begin
		request_t    r;
		int          push_pct;
		int          qlo;
		int          qhi;
		int unsigned burst_pick [6];

		tracker = new();
		stall_cycles = 0;
		cfg_writes = 0;
		idle_pct = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_burst(1);
		// pull with nothing queued, then edge values
		send_fields(CMD_PULL, 0, 0);
		send_fields(CMD_PUSH, 0, 8'h00);
		send_fields(CMD_PUSH, 7, 8'hff);
		send_fields(CMD_PUSH, 1, 8'h55);
		repeat (4) send_fields(CMD_PULL, 7, 8'hff);
		// fill one queue and push once more into it
		for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
			send_fields(CMD_PUSH, 6, 8'ha0 + i);
		end

		burst_pick[0] = 16;
		burst_pick[1] = 0;
		burst_pick[2] = 31;
		burst_pick[3] = 2;
		burst_pick[4] = 1;
		for (int s = 0; s < SEGMENTS; s++) begin
			if (s < 6) idle_pct = 37;
			else if (s < 12) idle_pct = 78;
			else idle_pct = 0;
			burst_pick[5] = $urandom_range(16, 1);
			write_burst(burst_pick[s % 6]);
			case ($urandom_range(2, 0))
				0: push_pct = 30;
				1: push_pct = 55;
				default: push_pct = 75;
			endcase
			// narrow queue windows fill queues and stress wraparound
			if ($urandom_range(1, 0) == 0) begin
				qlo = 0;
				qhi = NUM_QUEUES - 1;
			end else begin
				qlo = $urandom_range(NUM_QUEUES - 2, 0);
				qhi = qlo + 1;
			end
			for (int n = 0; n < SEG_ITEMS; n++) begin
				r.cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_PULL;
				r.queue_index = 3'($urandom_range(qhi, qlo));
				r.push_value = 8'($urandom_range(255, 0));
				send_request(r);
				if ($urandom_range(49) == 0) drain_results();
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (tracker.outstanding() != 0) begin
			$error("%0d expected results never arrived", tracker.outstanding());
			tracker.errors++;
		end
		$display("covered %0d pushes (%0d refused), %0d pulls (%0d on empty queues)",
			tracker.pushes, tracker.refused, tracker.pulls, tracker.dry_pulls);
		$display("burst size written %0d times, including 0, 1, 16 and 31", cfg_writes);
		if (tracker.errors == 0) begin
			$display("round_robin_burst_interleaver_unit: match");
		end else begin
			$display("round_robin_burst_interleaver_unit: mismatch");
		end
		$finish;
	end

endmodule
